@@ src/dslt_pkg.sv @@
`default_nettype none
package dslt_pkg;

  localparam int unsigned Sources = 16;
  localparam int unsigned IdxW = (Sources > 1) ? $clog2(Sources) : 1;
  localparam int unsigned FrameLen = 48;
  localparam int unsigned CntW = 6;
  localparam logic [47:0] CntMax = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned RecW = 32 + 48 + 48;

  typedef enum logic [2:0] {
    ST_FIRST    = 3'd0,
    ST_IN_ORDER = 3'd1,
    ST_GAP      = 3'd2,
    ST_LATE     = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BAD_MAGIC = 3'd5,
    ST_OWN_ID   = 3'd6,
    ST_FULL     = 3'd7
  } status_e;

  typedef enum logic {
    REG_OWN_ID = 1'b0,
    REG_MAGIC  = 1'b1
  } reg_e;

  typedef struct packed {
    logic        short_frame;
    logic [31:0] magic;
    logic [15:0] cam_num;
    logic [63:0] stamp_ns;
    logic [31:0] obj_num;
    logic [15:0] sender_id;
    logic [7:0]  object_type;
    logic [31:0] sequence_num;
    logic [31:0] heartbeat;
  } frame_t;

  typedef struct packed {
    logic [31:0] expected;
    logic [47:0] received;
    logic [47:0] lost;
  } rec_t;

endpackage
`default_nettype wire

@@ src/dslt_ram.sv @@
`default_nettype none
module dslt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/dslt_parse.sv @@
`default_nettype none
module dslt_parse (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            end_i,
  output dslt_pkg::frame_t     frame_o
);
  import dslt_pkg::*;

  logic [CntW-1:0] cnt_q;
  frame_t          frm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      if (end_i) begin
        cnt_q <= '0;
      end else if (cnt_q < CntW'(FrameLen)) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (end_i) begin
        frm_q.short_frame <= (cnt_q < CntW'(FrameLen - 1));
      end
      case (cnt_q) inside
        [0:3]:   frm_q.magic        <= {frm_q.magic[23:0], byte_i};
        [8:9]:   frm_q.cam_num      <= {frm_q.cam_num[7:0], byte_i};
        [10:17]: frm_q.stamp_ns     <= {frm_q.stamp_ns[55:0], byte_i};
        [18:21]: frm_q.obj_num      <= {frm_q.obj_num[23:0], byte_i};
        [22:23]: frm_q.sender_id    <= {frm_q.sender_id[7:0], byte_i};
        36:      frm_q.object_type  <= byte_i;
        [37:40]: frm_q.sequence_num <= {frm_q.sequence_num[23:0], byte_i};
        [41:44]: frm_q.heartbeat    <= {frm_q.heartbeat[23:0], byte_i};
        default: ;
      endcase
    end
  end

  assign frame_o = frm_q;

endmodule
`default_nettype wire

@@ src/datagram_sequence_loss_tracker.sv @@
`default_nettype none
// Datagram bytes are taken one per cycle whenever start is high and busy is
// low. The byte that carries end_of_datagram starts a table update during
// which busy is high: state S_LOOK alone for a datagram that is short, has a
// bad magic word, carries the own system id, is a new sender or finds the
// table full, and S_LOOK then S_CALC for a known sender, whose record is read
// from and written back to the per-sender RAM. The result then appears with
// valid_o high for exactly one cycle, in the same cycle that busy falls, and
// cannot be stalled; bytes of the next datagram may already be taken then.
module datagram_sequence_loss_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_datagram_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [15:0]      sender_id_o,
  output logic [31:0]      sequence_res_o,
  output logic [30:0]      gap_size_o,
  output logic [47:0]      packets_received_o,
  output logic [47:0]      packets_lost_o,
  output logic [31:0]      heartbeat_o,
  output logic [31:0]      obj_num_o,
  output logic [7:0]       object_type_o,
  output logic [15:0]      cam_num_o,
  output logic [63:0]      stamp_ns_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dslt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_CALC = 3'b100
  } state_e;

  state_e state_q;
  logic [15:0] own_id_q;
  logic [31:0] magic_q;
  logic        accept;
  frame_t      frm;

  logic [Sources-1:0] valid_q;
  logic [15:0]        key_q [Sources];
  logic [IdxW-1:0]    slot_q;

  logic            hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  rec_t            ram_wdata, ram_rdata;

  logic        frame_ok;
  logic [31:0] seq_delta;
  logic [48:0] lost_sum;
  logic [47:0] lost_sat, recv_sat;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [30:0] gap_q;
  logic [47:0] recv_q, lost_q;
  logic        fields_q;

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (reg_e'(paddr[2]) == REG_OWN_ID) ? {16'd0, own_id_q} : magic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= 16'd1;
      magic_q  <= 32'h4A47_3100;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        REG_OWN_ID: own_id_q <= pwdata[15:0];
        REG_MAGIC:  magic_q  <= pwdata;
        default: ;
      endcase
    end
  end

  dslt_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (data_byte_i),
    .end_i    (end_of_datagram_i),
    .frame_o  (frm)
  );

  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = Sources - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == frm.sender_id) begin
        hit = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign frame_ok = !frm.short_frame && frm.magic == magic_q &&
                    frm.sender_id != own_id_q;

  assign seq_delta = frm.sequence_num - ram_rdata.expected;
  assign lost_sum = {1'b0, ram_rdata.lost} + {17'd0, seq_delta};
  assign lost_sat = lost_sum[48] ? CntMax : lost_sum[47:0];
  assign recv_sat = (ram_rdata.received == CntMax) ? CntMax : ram_rdata.received + 48'd1;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = free_idx;
    ram_wdata.expected = frm.sequence_num + 32'd1;
    ram_wdata.received = 48'd1;
    ram_wdata.lost = '0;
    if (state_q == S_LOOK) begin
      ram_we = frame_ok && !hit && free;
    end else if (state_q == S_CALC) begin
      ram_we = 1'b1;
      ram_waddr = slot_q;
      ram_wdata.received = recv_sat;
      ram_wdata.lost = ram_rdata.lost;
      ram_wdata.expected = ram_rdata.expected;
      if (seq_delta == 32'd0) begin
        ram_wdata.expected = ram_rdata.expected + 32'd1;
      end else if (!seq_delta[31]) begin
        ram_wdata.lost = lost_sat;
        ram_wdata.expected = frm.sequence_num + 32'd1;
      end
    end
  end

  dslt_ram #(.Width(RecW), .Depth(Sources)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (hit_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && end_of_datagram_i) begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (frame_ok && hit) begin
            state_q <= S_CALC;
          end else begin
            state_q <= S_IDLE;
            out_valid_q <= 1'b1;
            if (frame_ok && free) begin
              valid_q[free_idx] <= 1'b1;
            end
          end
        end
        S_CALC: begin
          state_q <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      slot_q <= hit_idx;
      gap_q <= '0;
      recv_q <= '0;
      lost_q <= '0;
      fields_q <= !frm.short_frame && frm.magic == magic_q;
      if (frm.short_frame) begin
        status_q <= ST_SHORT;
      end else if (frm.magic != magic_q) begin
        status_q <= ST_BAD_MAGIC;
      end else if (frm.sender_id == own_id_q) begin
        status_q <= ST_OWN_ID;
      end else if (!hit && !free) begin
        status_q <= ST_FULL;
      end else if (!hit) begin
        status_q <= ST_FIRST;
        recv_q <= 48'd1;
        key_q[free_idx] <= frm.sender_id;
      end
    end else if (state_q == S_CALC) begin
      recv_q <= ram_wdata.received;
      lost_q <= ram_wdata.lost;
      if (seq_delta == 32'd0) begin
        status_q <= ST_IN_ORDER;
      end else if (!seq_delta[31]) begin
        status_q <= ST_GAP;
        gap_q <= seq_delta[30:0];
      end else begin
        status_q <= ST_LATE;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign status_o = status_q;
  assign gap_size_o = gap_q;
  assign packets_received_o = recv_q;
  assign packets_lost_o = lost_q;
  assign sender_id_o = fields_q ? frm.sender_id : '0;
  assign sequence_res_o = fields_q ? frm.sequence_num : '0;
  assign heartbeat_o = fields_q ? frm.heartbeat : '0;
  assign obj_num_o = fields_q ? frm.obj_num : '0;
  assign object_type_o = fields_q ? frm.object_type : '0;
  assign cam_num_o = fields_q ? frm.cam_num : '0;
  assign stamp_ns_o = fields_q ? frm.stamp_ns : '0;

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without a preceding update");

  a_gap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_GAP) |-> gap_size_o == '0)
    else $error("gap size set without gap status");

  a_recv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_FIRST || status_o == ST_IN_ORDER ||
                 status_o == ST_GAP || status_o == ST_LATE)) |-> packets_received_o != '0)
    else $error("tracked sender with zero received count");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> $past(state_q == S_IDLE))
    else $error("update entered from a wrong state");

endmodule
`default_nettype wire

@@ tb/datagram_sequence_loss_tracker_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module datagram_sequence_loss_tracker_test;
  import dslt_pkg::*;

  localparam int unsigned IdleLimit = 5000;

  typedef struct packed {
    status_e     status;
    logic [15:0] sender_id;
    logic [31:0] sequence_num;
    logic [30:0] gap_size;
    logic [47:0] received;
    logic [47:0] lost;
    logic [31:0] heartbeat;
    logic [31:0] obj_num;
    logic [7:0]  object_type;
    logic [15:0] cam_num;
    logic [63:0] stamp_ns;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [7:0]  data_byte_i;
  logic        end_of_datagram_i;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [15:0] sender_id_o;
  logic [31:0] sequence_res_o;
  logic [30:0] gap_size_o;
  logic [47:0] packets_received_o;
  logic [47:0] packets_lost_o;
  logic [31:0] heartbeat_o;
  logic [31:0] obj_num_o;
  logic [7:0]  object_type_o;
  logic [15:0] cam_num_o;
  logic [63:0] stamp_ns_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  datagram_sequence_loss_tracker u_dut (
    .clk_i, .rst_ni, .start, .busy, .data_byte_i, .end_of_datagram_i, .valid_o,
    .status_o, .sender_id_o, .sequence_res_o, .gap_size_o, .packets_received_o,
    .packets_lost_o, .heartbeat_o, .obj_num_o, .object_type_o, .cam_num_o,
    .stamp_ns_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Mirror of the block state.
  logic [15:0] own_id;
  logic [31:0] magic_word;
  logic [7:0]  frame_buf [FrameLen];
  int          frame_cnt;
  logic [15:0] src_key [Sources];
  bit          src_vld [Sources];
  logic [31:0] src_next [Sources];
  logic [47:0] src_rx [Sources];
  logic [47:0] src_lost [Sources];

  verdict_t    verdict_q[$];
  int          errors;
  int          moves;
  int          burst_left;
  bit          steady;
  logic [7:0]  dgram [64];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] be_bytes(int pos, int len);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < len; i++) v = (v << 8) | frame_buf[pos + i];
    return v;
  endfunction

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = a + b;
    return s[48] ? CntMax : s[47:0];
  endfunction

  task automatic track_byte(logic [7:0] b, logic eod);
    verdict_t r;
    int hit;
    int free_slot;
    int n;
    logic [31:0] d;
    hit = -1;
    free_slot = -1;
    if (frame_cnt < FrameLen) begin
      frame_buf[frame_cnt] = b;
      frame_cnt++;
    end
    if (!eod) return;
    n = frame_cnt;
    frame_cnt = 0;
    r = '0;
    if (n < FrameLen) begin
      r.status = ST_SHORT;
    end else if (32'(be_bytes(0, 4)) != magic_word) begin
      r.status = ST_BAD_MAGIC;
    end else begin
      r.sender_id = 16'(be_bytes(22, 2));
      r.sequence_num = 32'(be_bytes(37, 4));
      r.heartbeat = 32'(be_bytes(41, 4));
      r.obj_num = 32'(be_bytes(18, 4));
      r.object_type = frame_buf[36];
      r.cam_num = 16'(be_bytes(8, 2));
      r.stamp_ns = be_bytes(10, 8);
      if (r.sender_id == own_id) begin
        r.status = ST_OWN_ID;
      end else begin
        for (int i = 0; i < Sources; i++) begin
          if (src_vld[i]) begin
            if (hit < 0 && src_key[i] == r.sender_id) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit < 0 && free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          if (hit < 0) begin
            hit = free_slot;
            src_vld[hit] = 1'b1;
            src_key[hit] = r.sender_id;
            src_next[hit] = r.sequence_num + 32'd1;
            src_rx[hit] = 48'd1;
            src_lost[hit] = '0;
            r.status = ST_FIRST;
          end else begin
            d = r.sequence_num - src_next[hit];
            if (d == 32'd0) begin
              src_next[hit] = src_next[hit] + 32'd1;
              r.status = ST_IN_ORDER;
            end else if (!d[31]) begin
              src_lost[hit] = sat48(src_lost[hit], {16'd0, d});
              src_next[hit] = r.sequence_num + 32'd1;
              r.status = ST_GAP;
              r.gap_size = d[30:0];
            end else begin
              r.status = ST_LATE;
            end
            src_rx[hit] = sat48(src_rx[hit], 48'd1);
          end
          r.received = src_rx[hit];
          r.lost = src_lost[hit];
        end
      end
    end
    verdict_q.push_back(r);
  endtask

  always @(negedge clk_i) begin
    verdict_t w;
    if (rst_ni && valid_o) begin
      moves++;
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", status_o, '0);
      end else begin
        w = verdict_q.pop_front();
        if (status_o != w.status) report_mismatch("status", status_o, w.status);
        if (sender_id_o != w.sender_id)
          report_mismatch("sender_id", sender_id_o, w.sender_id);
        if (sequence_res_o != w.sequence_num)
          report_mismatch("sequence", sequence_res_o, w.sequence_num);
        if (gap_size_o != w.gap_size) report_mismatch("gap_size", gap_size_o, w.gap_size);
        if (packets_received_o != w.received)
          report_mismatch("received", packets_received_o, w.received);
        if (packets_lost_o != w.lost) report_mismatch("lost", packets_lost_o, w.lost);
        if (heartbeat_o != w.heartbeat) report_mismatch("heartbeat", heartbeat_o, w.heartbeat);
        if (obj_num_o != w.obj_num) report_mismatch("obj_num", obj_num_o, w.obj_num);
        if (object_type_o != w.object_type)
          report_mismatch("object_type", object_type_o, w.object_type);
        if (cam_num_o != w.cam_num) report_mismatch("cam_num", cam_num_o, w.cam_num);
        if (stamp_ns_o != w.stamp_ns)
          report_mismatch("stamp", stamp_ns_o, w.stamp_ns);
      end
    end
  end

  initial begin
    int idle;
    int seen;
    idle = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (moves != seen || psel) begin
        seen = moves;
        idle = 0;
      end else if (++idle >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eod);
    bit taken;
    if (!steady && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    start <= 1'b1;
    data_byte_i <= b;
    end_of_datagram_i <= eod;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    moves++;
    track_byte(b, eod);
  endtask

  task automatic send_dgram(int len);
    for (int i = 0; i < len; i++) send_byte(dgram[i % 64], i == len - 1);
  endtask

  task automatic build(logic [31:0] mg, logic [15:0] sid, logic [31:0] seq, bit ones = 0);
    logic [63:0] ts;
    for (int i = 0; i < 64; i++) dgram[i] = ones ? 8'hFF : 8'($urandom);
    for (int i = 0; i < 4; i++) dgram[i] = mg[31 - 8 * i -: 8];
    dgram[22] = sid[15:8];
    dgram[23] = sid[7:0];
    for (int i = 0; i < 4; i++) dgram[37 + i] = seq[31 - 8 * i -: 8];
    ts = {$urandom, $urandom};
    if (!ones) for (int i = 0; i < 8; i++) dgram[10 + i] = ts[63 - 8 * i -: 8];
  endtask

  task automatic quiesce();
    start <= 1'b0;
    end_of_datagram_i <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_OWN_ID) ? {16'd0, value[15:0]} : value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (!pready) report_mismatch("pready", 64'(pready), 64'd1);
    if (prdata != want) report_mismatch("readback", prdata, want);
    if (idx == REG_OWN_ID) own_id = value[15:0];
    else magic_word = value;
  endtask

  function automatic logic [31:0] next_of(logic [15:0] sid);
    for (int i = 0; i < Sources; i++) if (src_vld[i] && src_key[i] == sid) return src_next[i];
    return $urandom;
  endfunction

  task automatic test_tracking();
    steady = 1;
    build(magic_word, 16'd2, 32'hFFFF_FFFF); send_dgram(48);
    build(magic_word, 16'd2, 32'h0000_0000); send_dgram(48);
    build(magic_word, 16'd2, 32'd5); send_dgram(48);
    build(magic_word, 16'd2, 32'd3); send_dgram(48);
    build(magic_word, 16'd2, 32'd5); send_dgram(48);
    build(magic_word, 16'd2, 32'd6 + 32'h7FFF_FFFF); send_dgram(48);
    build(magic_word, 16'd2, next_of(16'd2) + 32'h8000_0000); send_dgram(48);
    build(magic_word, 16'd3, 32'd0, 1); send_dgram(48);
    build(magic_word, 16'd3, 32'd7); send_dgram(60);
    build(magic_word, own_id, 32'd9); send_dgram(48);
    build(~magic_word, 16'd3, 32'd8); send_dgram(48);
    build(magic_word, 16'd3, 32'd8); send_dgram(1);
    send_dgram(47);
    steady = 0;
  endtask

  task automatic test_registers();
    quiesce();
    write_reg(REG_OWN_ID, 32'h0000);
    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    build(32'hFFFF_FFFF, 16'd0, 32'd1); send_dgram(48);
    build(32'hFFFF_FFFF, 16'hFFFF, 32'd1); send_dgram(48);
    build(32'h4A47_3100, 16'd4, 32'd1); send_dgram(48);
    quiesce();
    write_reg(REG_OWN_ID, 32'hFFFF);
    write_reg(REG_MAGIC, 32'h0000_0000);
    build(32'h0, 16'hFFFF, 32'd1); send_dgram(48);
    build(32'h0, 16'd0, 32'd1); send_dgram(48);
    quiesce();
    write_reg(REG_OWN_ID, 32'd1);
    write_reg(REG_MAGIC, 32'h4A47_3100);
  endtask

  task automatic random_traffic(int n);
    logic [15:0] sid;
    logic [31:0] seq;
    int k;
    for (int j = 0; j < n; j++) begin
      if (j % 20 == 0) steady = $urandom_range(0, 3) == 0;
      sid = 16'($urandom_range(2, 9));
      seq = next_of(sid);
      k = $urandom_range(0, 99);
      if (k < 20) seq = seq + 32'($urandom_range(1, 5));
      else if (k < 30) seq = seq - 32'($urandom_range(1, 5));
      else if (k < 35) seq = $urandom;
      build(magic_word, sid, seq);
      k = $urandom_range(0, 99);
      if (k < 8) send_dgram($urandom_range(1, 47));
      else if (k < 14) begin
        dgram[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        send_dgram(48);
      end else if (k < 20) send_dgram($urandom_range(49, 64));
      else send_dgram(48);
    end
    steady = 0;
  endtask

  task automatic test_random();
    random_traffic(4);
    quiesce();
    write_reg(REG_OWN_ID, 32'd5);
    write_reg(REG_MAGIC, $urandom);
    random_traffic(3);
    quiesce();
    write_reg(REG_OWN_ID, 32'd1);
    write_reg(REG_MAGIC, 32'h4A47_3100);
    random_traffic(3);
  endtask

  task automatic test_table_full();
    int n_free;
    n_free = 0;
    for (int i = 0; i < Sources; i++) if (!src_vld[i]) n_free++;
    for (int i = 0; i <= n_free; i++) begin
      build(magic_word, 16'(16'h100 + i), $urandom);
      send_dgram(48);
    end
    build(magic_word, 16'd2, next_of(16'd2)); send_dgram(48);
  endtask

  initial begin
    errors = 0;
    moves = 0;
    burst_left = 0;
    steady = 0;
    own_id = 16'd1;
    magic_word = 32'h4A47_3100;
    frame_cnt = 0;
    for (int i = 0; i < Sources; i++) src_vld[i] = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    data_byte_i = '0;
    end_of_datagram_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tracking();
    test_registers();
    test_random();
    test_table_full();
    quiesce();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
src/dslt_pkg.sv
src/dslt_ram.sv
src/dslt_parse.sv
src/datagram_sequence_loss_tracker.sv
tb/datagram_sequence_loss_tracker_test.sv
